/* hw/rtl/sct_pkg.sv */
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the sparse chunked tile store
// Chunk geometry, memory sizes, request/response beats, slot table links.
// ----------------------------------------------------------------------------
package sct_pkg;

    // CHUNK_DIM must be a power of two: the floor split is a shift and a mask
    localparam int CHUNK_DIM   = 16;
    localparam int CHUNK_SLOTS = 16;
    localparam int CELL_BITS   = 16;

    localparam int LOC_W      = $clog2(CHUNK_DIM);
    localparam int SLOT_W     = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
    localparam int CHUNK_AREA = CHUNK_DIM * CHUNK_DIM;
    localparam int CELL_DEPTH = CHUNK_SLOTS * CHUNK_AREA;
    localparam int ADDR_W     = $clog2(CELL_DEPTH);
    localparam int OCC_W      = $clog2(CHUNK_AREA + 1);
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 16;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_SET    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [1:0]        func;
        logic signed [15:0] tile_x;
        logic signed [15:0] tile_y;
        logic [15:0]       cell_value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] read_value;
    } t_rsp;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_slot;
        logic              free_ok;
        logic [SLOT_W-1:0] free_slot;
    } t_lookup;

    typedef struct packed {
        logic              alloc;
        logic              inc;
        logic              dec;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
    } t_update;

endpackage

/* hw/rtl/sct_if.sv */
// ----------------------------------------------------------------------------
// sct_req_if / sct_rsp_if: valid/ready channels of the tile store
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface sct_req_if;
    logic          valid;
    logic          ready;
    sct_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sct_rsp_if;
    logic          valid;
    logic          ready;
    sct_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/sct_ram.sv */
// ----------------------------------------------------------------------------
// sct_ram: generic single-write, single-read RAM
// Registered read data.
// ----------------------------------------------------------------------------
module sct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/sct_slot_table.sv */
// ----------------------------------------------------------------------------
// sct_slot_table: chunk slot tags, valid bits and occupancy counts
// Parallel tag match with lowest free slot search; applies slot updates.
// ----------------------------------------------------------------------------
module sct_slot_table (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [sct_pkg::KEY_W-1:0]        i_key,
    output sct_pkg::t_lookup                 o_lookup,
    input  logic                             i_upd_en,
    input  sct_pkg::t_update                 i_upd
);

    logic [sct_pkg::CHUNK_SLOTS-1:0] r_valid;
    logic [sct_pkg::KEY_W-1:0]       r_key [sct_pkg::CHUNK_SLOTS];
    logic [sct_pkg::OCC_W-1:0]       r_occ [sct_pkg::CHUNK_SLOTS];
    logic [sct_pkg::OCC_W-1:0]       n_occ;
    sct_pkg::t_lookup                lk;

    // Lowest index wins on both searches
    always_comb begin
        lk = '0;
        for (int i = sct_pkg::CHUNK_SLOTS - 1; i >= 0; i--) begin
            if (r_valid[i] && r_key[i] == i_key) begin
                lk.hit      = 1'b1;
                lk.hit_slot = sct_pkg::SLOT_W'(i);
            end
            if (!r_valid[i]) begin
                lk.free_ok   = 1'b1;
                lk.free_slot = sct_pkg::SLOT_W'(i);
            end
        end
    end

    assign o_lookup = lk;

    always_comb begin
        n_occ = i_upd.alloc ? '0 : r_occ[i_upd.slot];
        if (i_upd.inc) begin
            n_occ = n_occ + 1'b1;
        end else if (i_upd.dec && n_occ != '0) begin
            n_occ = n_occ - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < sct_pkg::CHUNK_SLOTS; i++) begin
                r_occ[i] <= '0;
            end
        end else if (i_upd_en) begin
            r_occ[i_upd.slot] <= n_occ;
            if (i_upd.alloc) begin
                r_valid[i_upd.slot] <= 1'b1;
            end else if (i_upd.dec && n_occ == '0) begin
                r_valid[i_upd.slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd_en && i_upd.alloc) begin
            r_key[i_upd.slot] <= i_upd.key;
        end
    end

endmodule

/* hw/rtl/sparse_chunked_tile_store_top.sv */
// ----------------------------------------------------------------------------
// sparse_chunked_tile_store_top: sparse 2D tile grid held in square chunks
//
// Request channel i_req carries func, tile_x, tile_y and cell_value; each
// request beat yields exactly one response beat on o_rsp with status and
// read_value. The coordinate splits into a chunk key (floor shift) and a
// cell offset (low bits). The chunk key is matched against all slot tags in
// the accept cycle, and the cell memory read is issued in that same cycle.
// In the next cycle the read data returns, the result is formed, the cell is
// written back and the slot occupancy/valid bits are updated.
// The response is registered from the execute state. Requests are taken only
// in the idle state, so a new request waits until the last one has left the
// execute state, as the read-then-write of the single cell memory requires;
// no two accesses to the same cell ever overlap.
// After reset the cell memory is swept to zero, one entry per cycle, over all
// CELL_DEPTH (4096) entries; i_req.ready stays low during the sweep.
// A stalled receiver holds the response in the output register; a new
// request is still taken as long as that register drains in the same cycle.
// ----------------------------------------------------------------------------
module sparse_chunked_tile_store_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sct_req_if.sink       i_req,
    sct_rsp_if.source     o_rsp
);

    sct_pkg::t_state r_state, n_state;

    logic [sct_pkg::ADDR_W:0]   r_clr_cnt;
    logic                       acc;
    logic signed [15:0]         cx, cy;
    logic [sct_pkg::KEY_W-1:0]  key;
    sct_pkg::t_lookup           lk;
    logic [sct_pkg::SLOT_W-1:0] sel_slot;
    logic [sct_pkg::ADDR_W-1:0] rd_addr;

    // Held request context for the execute cycle
    logic [1:0]                 r_func;
    logic [sct_pkg::VAL_W-1:0]  r_value;
    logic                       r_hit;
    logic                       r_slot_ok;
    logic [sct_pkg::SLOT_W-1:0] r_slot;
    logic [sct_pkg::KEY_W-1:0]  r_key;
    logic [sct_pkg::ADDR_W-1:0] r_addr;

    logic [sct_pkg::VAL_W-1:0]  rdata;
    logic                       mem_we;
    logic [sct_pkg::ADDR_W-1:0] mem_waddr;
    logic [sct_pkg::VAL_W-1:0]  mem_wdata;
    logic                       exec_we;
    logic [sct_pkg::VAL_W-1:0]  exec_wdata;
    logic                       upd_en;
    sct_pkg::t_update           upd;
    sct_pkg::t_rsp              rsp;

    logic                       r_out_valid;
    sct_pkg::t_rsp              r_out;

    assign acc = i_req.valid && i_req.ready;

    // Floor quotient and non-negative remainder by a power-of-two chunk size
    assign cx  = i_req.data.tile_x >>> sct_pkg::LOC_W;
    assign cy  = i_req.data.tile_y >>> sct_pkg::LOC_W;
    assign key = {cy, cx};

    sct_slot_table u_slots (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (key),
        .o_lookup (lk),
        .i_upd_en (upd_en),
        .i_upd    (upd)
    );

    // On a miss point at the free slot: its cells are all empty
    assign sel_slot = lk.hit ? lk.hit_slot : lk.free_slot;
    assign rd_addr  = {sel_slot,
                       i_req.data.tile_y[sct_pkg::LOC_W-1:0],
                       i_req.data.tile_x[sct_pkg::LOC_W-1:0]};

    sct_ram #(
        .WIDTH (sct_pkg::VAL_W),
        .DEPTH (sct_pkg::CELL_DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // Execute: form the response and the write-back
    always_comb begin
        rsp        = '{status: sct_pkg::ST_ABSENT, read_value: '0};
        exec_we    = 1'b0;
        exec_wdata = r_value;
        upd        = '{alloc: 1'b0, inc: 1'b0, dec: 1'b0, slot: r_slot, key: r_key};
        unique case (r_func)
            sct_pkg::FUNC_LOOKUP: begin
                if (r_hit && rdata != '0) begin
                    rsp.status     = sct_pkg::ST_DONE;
                    rsp.read_value = rdata;
                end
            end
            sct_pkg::FUNC_SET: begin
                if (r_value == '0) begin
                    rsp.status = sct_pkg::ST_EMPTY;
                end else if (!r_slot_ok) begin
                    rsp.status = sct_pkg::ST_FULL;
                end else begin
                    upd.alloc = !r_hit;
                    if (rdata != r_value) begin
                        rsp.status = sct_pkg::ST_DONE;
                        exec_we    = 1'b1;
                        upd.inc    = (rdata == '0);
                    end
                end
            end
            sct_pkg::FUNC_REMOVE: begin
                if (r_hit && rdata != '0) begin
                    rsp.status = sct_pkg::ST_DONE;
                    exec_we    = 1'b1;
                    exec_wdata = '0;
                    upd.dec    = 1'b1;
                end
            end
            default: begin
                rsp.status = sct_pkg::ST_ABSENT;
            end
        endcase
    end

    assign upd_en = (r_state == sct_pkg::S_EXEC);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = exec_wdata;
        if (r_state == sct_pkg::S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_cnt[sct_pkg::ADDR_W-1:0];
            mem_wdata = '0;
        end else if (r_state == sct_pkg::S_EXEC) begin
            mem_we = exec_we;
        end
    end

    assign i_req.ready = (r_state == sct_pkg::S_IDLE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sct_pkg::S_CLEAR: begin
                if (r_clr_cnt == (sct_pkg::ADDR_W + 1)'(sct_pkg::CELL_DEPTH - 1)) begin
                    n_state = sct_pkg::S_IDLE;
                end
            end
            sct_pkg::S_IDLE: begin
                if (acc) begin
                    n_state = sct_pkg::S_EXEC;
                end
            end
            sct_pkg::S_EXEC: begin
                n_state = sct_pkg::S_IDLE;
            end
            default: begin
                n_state = sct_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sct_pkg::S_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == sct_pkg::S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (r_state == sct_pkg::S_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: capture on accept, hold otherwise; r_out captures in execute
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_func    <= i_req.data.func;
            r_value   <= i_req.data.cell_value & sct_pkg::VAL_W'((17'd1 << sct_pkg::CELL_BITS) - 1);
            r_hit     <= lk.hit;
            r_slot_ok <= lk.hit || lk.free_ok;
            r_slot    <= sel_slot;
            r_key     <= key;
            r_addr    <= rd_addr;
        end
        if (r_state == sct_pkg::S_EXEC) begin
            r_out <= rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // No request is taken during the clear sweep
    a_no_req_in_clear: assert property (@(posedge i_clk)
        (r_state == sct_pkg::S_CLEAR) |-> !i_req.ready)
        else $error("request ready during clear sweep");

    // Every accepted request shows a response once the execute state has registered it
    a_rsp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> ##1 o_rsp.valid)
        else $error("response missing after request");

    // A cell write outside the sweep only happens in the execute cycle
    a_write_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && r_state != sct_pkg::S_CLEAR) |-> upd_en)
        else $error("cell write outside execute");

endmodule
